// File: rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// Matrix vector transform package
// Shared widths, types, item kinds and the Q16.16 round and saturate helper.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int DIM        = 4;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int ACC_W      = PROD_W + $clog2(DIM);
   localparam int FRAC_W     = 16;
   localparam int IDX_W      = $clog2(DIM * DIM);
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = ((IDX_W + (2 + DIM) * WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = DIM * WORD_W;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_XFORM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SCALE = 2'd2;

   localparam logic [WORD_W-1:0] Q_ONE = WORD_W'(1) << FRAC_W;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef struct packed {
      logic     sat;
      word_type value;
   } rnd_type;

   // Round a Q34.32 value to nearest Q16.16 (ties toward plus infinity),
   // then clip to the signed 32-bit range.
   function automatic rnd_type rnd_sat(input acc_type v);
      acc_type sum;
      acc_type sh;
      rnd_type r;
      sum = v + acc_type'(ACC_W'(1) << (FRAC_W - 1));
      sh  = sum >>> FRAC_W;
      if ((&sh[ACC_W-1:WORD_W-1]) || !(|sh[ACC_W-1:WORD_W-1])) begin
         r.sat   = 1'b0;
         r.value = sh[WORD_W-1:0];
      end else begin
         r.sat   = 1'b1;
         r.value = sh[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/matrix_vector_transform.sv
// ----------------------------------------------------------------------------
// Matrix vector transform
// A 4x4 Q16.16 matrix with load, uniform scale and row-vector transform items.
// ----------------------------------------------------------------------------
// A transform item's result goes from the product registers to the sum register
// and then to the output register; a stalled output side holds it.
// Throughput: one transform or load item per cycle while the output side is not
// stalled, set by the four column lanes of four multipliers each; a scale item
// occupies the multipliers and holds the input while the matrix is written back.
// Reset: synchronous, active high; the matrix returns to identity and the
// pipeline and output register are emptied.
module matrix_vector_transform (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: elem_index, elem_value, scale_factor, vec_x, vec_y,
   // vec_z, vec_w, zero fill.
   input  logic [mvt_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: mode.
   input  logic [mvt_pkg::MODE_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: res_x, res_y, res_z, res_w.
   output logic [mvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: saturated.
   output logic                           rsp_tuser
);
   import mvt_pkg::*;

   localparam int VAL_LO = IDX_W;
   localparam int SCL_LO = IDX_W + WORD_W;
   localparam int VEC_LO = IDX_W + 2 * WORD_W;

   word_type           mat_ff [DIM*DIM];
   logic               s1_v_ff;
   logic               s1_v_in;
   logic               s1_scale_ff;
   logic               s1_scale_in;
   logic               s2_v_ff;
   logic               s2_v_in;
   logic               accept;
   logic               issue;
   logic               do_load;
   logic               do_scale;
   logic               mv12;
   logic               adv2;
   logic               adv3;
   logic [IDX_W-1:0]   elem_index;
   word_type           elem_value;
   word_type           scale_factor;
   word_type [DIM-1:0] opnd_a;
   word_type [DIM-1:0] opnd_m [DIM];
   prod_type [DIM-1:0] lane_prod [DIM];
   rnd_type  [DIM-1:0] lane_rnd;
   rnd_type            scl_rnd [DIM*DIM];

   assign elem_index   = req_tdata[IDX_W-1:0];
   assign elem_value   = req_tdata[VAL_LO +: WORD_W];
   assign scale_factor = req_tdata[SCL_LO +: WORD_W];

   assign accept   = req_tvalid && req_tready;
   assign do_load  = accept && (req_tuser == MODE_LOAD);
   assign issue    = accept && ((req_tuser == MODE_XFORM) || (req_tuser == MODE_SCALE));
   assign do_scale = s1_v_ff && s1_scale_ff;

   assign adv2       = !s2_v_ff || adv3;
   assign mv12       = s1_v_ff && !s1_scale_ff && adv2;
   assign req_tready = !s1_v_ff || (!s1_scale_ff && adv2);

   assign s1_v_in     = issue ? 1'b1 : ((mv12 || s1_scale_ff) ? 1'b0 : s1_v_ff);
   assign s1_scale_in = issue ? (req_tuser == MODE_SCALE) : s1_scale_ff;
   assign s2_v_in     = mv12 ? 1'b1 : (adv3 ? 1'b0 : s2_v_ff);

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         opnd_a[i] = (req_tuser == MODE_SCALE) ? scale_factor
                                               : req_tdata[VEC_LO + i*WORD_W +: WORD_W];
         for (int j = 0; j < DIM; j++) begin
            opnd_m[j][i] = mat_ff[i*DIM + j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            scl_rnd[i*DIM + j] = rnd_sat(acc_type'($signed(lane_prod[j][i])));
         end
      end
   end

   for (genvar j = 0; j < DIM; j++) begin : g_lane
      mvt_lane u_lane (
         .clock  (clock),
         .ld1    (issue),
         .ld2    (mv12),
         .opnd_a (opnd_a),
         .opnd_m (opnd_m[j]),
         .prod   (lane_prod[j]),
         .rnd    (lane_rnd[j])
      );
   end

   mvt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ld         (s2_v_ff && adv3),
      .lane_rnd   (lane_rnd),
      .adv        (adv3),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s1_scale_ff <= 1'b0;
         s2_v_ff     <= 1'b0;
         for (int k = 0; k < DIM*DIM; k++) begin
            mat_ff[k] <= ((k / DIM) == (k % DIM)) ? Q_ONE : '0;
         end
      end else begin
         s1_v_ff     <= s1_v_in;
         s1_scale_ff <= s1_scale_in;
         s2_v_ff     <= s2_v_in;
         if (do_load) begin
            mat_ff[elem_index] <= elem_value;
         end else if (do_scale) begin
            for (int k = 0; k < DIM*DIM; k++) begin
               mat_ff[k] <= scl_rnd[k].value;
            end
         end
      end
   end

   // A scale item in the multiplier stage must block new items.
   a_scale_blocks: assert property (@(posedge clock) disable iff (reset)
      do_scale |-> !req_tready)
      else $error("item accepted while a scale item was writing back");

   // A scale item has left the multiplier stage by the next cycle.
   a_scale_drains: assert property (@(posedge clock) disable iff (reset)
      do_scale |=> !s1_v_ff)
      else $error("scale item stayed in the multiplier stage");

   // A stalled sum stage keeps its item.
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !adv3) |=> s2_v_ff)
      else $error("sum stage item lost under backpressure");

   // A new output item must come from the sum stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s2_v_ff))
      else $error("output item appeared without a source");

endmodule

// File: rtl/mvt_lane.sv
// ----------------------------------------------------------------------------
// Matrix vector transform lane
// One matrix column: four registered products, then a registered full-width
// sum, followed by rounding and saturation of that sum.
// ----------------------------------------------------------------------------
module mvt_lane (
   input  logic                                clock,
   input  logic                                ld1,
   input  logic                                ld2,
   input  mvt_pkg::word_type [mvt_pkg::DIM-1:0] opnd_a,
   input  mvt_pkg::word_type [mvt_pkg::DIM-1:0] opnd_m,
   output mvt_pkg::prod_type [mvt_pkg::DIM-1:0] prod,
   output mvt_pkg::rnd_type                     rnd
);
   import mvt_pkg::*;

   prod_type [DIM-1:0] prod_ff;
   prod_type [DIM-1:0] prod_in;
   acc_type            sum_ff;
   acc_type            sum_in;

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         prod_in[i] = $signed(opnd_a[i]) * $signed(opnd_m[i]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < DIM; i++) begin
         sum_in = sum_in + acc_type'($signed(prod_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         prod_ff <= prod_in;
      end
      if (ld2) begin
         sum_ff <= sum_in;
      end
   end

   assign prod = prod_ff;
   assign rnd  = rnd_sat(sum_ff);

endmodule

// File: rtl/mvt_merge.sv
// ----------------------------------------------------------------------------
// Matrix vector transform merge stage
// Collects the four lane results into one output item and combines the
// saturation flags, holding the item until the consumer takes it.
// ----------------------------------------------------------------------------
module mvt_merge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ld,
   input  mvt_pkg::rnd_type [mvt_pkg::DIM-1:0]    lane_rnd,
   output logic                                   adv,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [mvt_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser
);
   import mvt_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [RSP_DATA_W-1:0] data_in;
   logic                  sat_ff;
   logic                  sat_in;

   assign adv = !valid_ff || rsp_tready;

   always_comb begin
      sat_in = 1'b0;
      for (int j = 0; j < DIM; j++) begin
         data_in[j*WORD_W +: WORD_W] = lane_rnd[j].value;
         sat_in = sat_in | lane_rnd[j].sat;
      end
   end

   assign valid_in = ld ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ld) begin
         data_ff <= data_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = sat_ff;

endmodule
